// ===== rtl/pwm_channel_allocator_core_defines.svh =====
// Assertion macros shared by the channel allocator modules
`ifndef PWM_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH
`define PWM_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PCA_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pca assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PCA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pca assertion failed");

`endif

// ===== rtl/pca_pkg.sv =====
// Types, codes and constants shared by the channel allocator modules
package pca_pkg;

    localparam int CHANNELS_DEF = 16;

    localparam logic [26:0] FREQ_MAX      = 27'd80000000;
    localparam logic [26:0] FREQ_RESET    = 27'd5000;
    localparam logic [4:0]  RES_RESET     = 5'd8;
    localparam logic [4:0]  RES_MIN       = 5'd1;
    localparam logic [4:0]  RES_MAX       = 5'd16;
    localparam logic [16:0] DUTY_MAX      = 17'd65536;
    localparam logic [26:0] SERVO_FREQ    = 27'd50;
    localparam logic [4:0]  SERVO_RES     = 5'd12;
    localparam logic [26:0] SERVO_DEG_LIM = 27'd200;
    localparam logic [26:0] SERVO_US_LIM  = 27'd4000;
    localparam logic [26:0] SERVO_US_MID  = 27'd600;
    localparam logic [16:0] SERVO_BASE    = 17'd123;
    localparam logic [8:0]  SERVO_GAIN    = 9'd369;
    localparam logic [10:0] DIV_DEG       = 11'd180;
    localparam logic [10:0] DIV_US        = 11'd1800;
    localparam int          RECIP_SHIFT   = 21;
    localparam logic [13:0] RECIP_DEG     = 14'd11650;
    localparam logic [13:0] RECIP_US      = 14'd1165;

    typedef enum logic [2:0] {
        CMD_DUTY     = 3'd0,
        CMD_SERVO    = 3'd1,
        CMD_PIN_FREQ = 3'd2,
        CMD_PIN_RES  = 3'd3,
        CMD_ALL_FREQ = 3'd4,
        CMD_ALL_RES  = 3'd5
    } cmd_code_t;

    typedef enum logic [1:0] {
        ACT_ATTACH = 2'd0,
        ACT_SETUP  = 2'd1,
        ACT_WRITE  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        K_ATTACH_CH,
        K_ATTACH_IDX,
        K_DUTY,
        K_SERVO_SETUP,
        K_SERVO_DUTY,
        K_SET_FREQ,
        K_SET_RES
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_L_RD,
        S_L_CMP,
        S_CLAIM_RD,
        S_CLAIM_EMIT,
        S_CH_RD,
        S_ACT,
        S_SV_MUL,
        S_SV_DIV,
        S_SV_OUT,
        S_G_RD,
        S_G_CMP,
        S_FIN
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [3:0]  channel;
        logic [5:0]  pin;
        logic [26:0] freq;
        logic [4:0]  res;
        logic [16:0] duty;
    } result_t;

    typedef struct packed {
        logic  load;
        logic  glob_wr;
        logic  idx_inc;
        logic  sel_ch;
        logic  rec_free;
        logic  set_ch_hit;
        logic  claim;
        logic  push;
        kind_t kind;
        logic  flush;
        logic  sv_mul;
        logic  sv_div;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       hit;
        logic       free_here;
        logic       free_found;
        logic       idx_last;
        logic       out_free;
        logic       pend_vld;
        logic       servo_wr;
    } ctrl_stat_t;

endpackage

// ===== rtl/pwm_channel_allocator_core.sv =====
// Top level of the PWM channel allocator: controller plus datapath
//
//  channel | valid     | stall     | fields
//  request | in_valid  | in_stall  | command, pin, value
//  result  | out_valid | out_stall | action, channel, pin_out, frequency, resolution, duty, last
//
// The lookup and global sweeps read, then check, one pin-RAM entry at a time (read state, then compare state).
// Reset: all channels free at 5000 Hz and 8 bits at once, no clearing pass.
// One request at a time; in_stall is high from acceptance until the last result is staged.
// out_stall holds the result register; the sweep waits when it must push a result while that register is held.
module pwm_channel_allocator_core #(
    parameter int CHANNELS = pca_pkg::CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [5:0]  pin,
    input  logic [26:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [3:0]  channel,
    output logic [5:0]  pin_out,
    output logic [26:0] frequency,
    output logic [4:0]  resolution,
    output logic [16:0] duty,
    output logic        last
);

    import pca_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t st;

    pca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    pca_dp #(.CHANNELS(CHANNELS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .command    (command),
        .pin        (pin),
        .value      (value),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .action     (action),
        .channel    (channel),
        .pin_out    (pin_out),
        .frequency  (frequency),
        .resolution (resolution),
        .duty       (duty),
        .last       (last)
    );

endmodule

// ===== rtl/pca_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module pca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pca_dp.sv =====
// Datapath: channel table, lookup scan, servo arithmetic and result staging
`include "pwm_channel_allocator_core_defines.svh"

module pca_dp #(
    parameter int CHANNELS = pca_pkg::CHANNELS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pca_pkg::ctrl_cmd_t     cmd,
    output pca_pkg::ctrl_stat_t    st,
    input  logic [2:0]             command,
    input  logic [5:0]             pin,
    input  logic [26:0]            value,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [1:0]             action,
    output logic [3:0]             channel,
    output logic [5:0]             pin_out,
    output logic [26:0]            frequency,
    output logic [4:0]             resolution,
    output logic [16:0]            duty,
    output logic                   last
);

    import pca_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

    logic [2:0]          cmd_reg;
    logic [5:0]          pin_reg;
    logic [26:0]         value_reg;
    logic [CH_W-1:0]     idx_reg, idx_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [CH_W-1:0]     free_reg, free_next;
    logic                free_found_reg, free_found_next;
    logic [CHANNELS-1:0] bound_reg, bound_next;
    logic [CHANNELS-1:0] ovr_f_reg, ovr_f_next;
    logic [CHANNELS-1:0] ovr_r_reg, ovr_r_next;
    logic [26:0]         glob_freq_reg, glob_freq_next;
    logic [4:0]          glob_res_reg, glob_res_next;
    logic [20:0]         prod_reg;
    logic                neg_reg;
    logic                us_reg;
    logic [9:0]          q0_reg;
    logic                pend_vld_reg, pend_vld_next;
    result_t             pend_reg, pend_next;
    logic                out_vld_reg, out_vld_next;
    result_t             out_reg, out_next;
    logic                out_last_reg, out_last_next;

    logic [CH_W-1:0]     rd_idx;
    logic [CH_W-1:0]     free_sel;
    logic [5:0]          pin_rd;
    logic [26:0]         freq_rd;
    logic [4:0]          res_rd;
    logic [26:0]         freq_sat;
    logic [4:0]          res_clamp;
    logic [16:0]         duty_sat;
    logic [26:0]         eff_freq;
    logic [4:0]          eff_res;
    logic                hit;
    logic                free_here;
    logic                out_free;
    logic                lt_deg;
    logic                us_hi;
    logic [11:0]         diff;
    logic [20:0]         prod_calc;
    logic [13:0]         recip;
    logic [10:0]         div_d;
    logic [34:0]         q_prod;
    logic [21:0]         rem;
    logic [9:0]          q_fix;
    logic [16:0]         sv_duty;
    logic [CH_W+3:0]     ch_wide;
    logic [CH_W+3:0]     idx_wide;
    result_t             new_res;

    assign rd_idx   = cmd.sel_ch ? ch_reg : idx_reg;
    assign free_sel = free_found_reg ? free_reg : idx_reg;

    pca_ram #(.WIDTH(6), .DEPTH(CHANNELS)) u_pin_ram (
        .clk   (clk),
        .we    (cmd.claim),
        .waddr (free_sel),
        .wdata (pin_reg),
        .raddr (rd_idx),
        .rdata (pin_rd)
    );

    pca_ram #(.WIDTH(27), .DEPTH(CHANNELS)) u_freq_ram (
        .clk   (clk),
        .we    (cmd.push && (cmd.kind == K_SET_FREQ)),
        .waddr (ch_reg),
        .wdata (freq_sat),
        .raddr (rd_idx),
        .rdata (freq_rd)
    );

    pca_ram #(.WIDTH(5), .DEPTH(CHANNELS)) u_res_ram (
        .clk   (clk),
        .we    (cmd.push && (cmd.kind == K_SET_RES)),
        .waddr (ch_reg),
        .wdata (res_clamp),
        .raddr (rd_idx),
        .rdata (res_rd)
    );

    always_comb
    begin
        freq_sat = (value_reg > FREQ_MAX) ? FREQ_MAX : value_reg;
        if (value_reg < {22'd0, RES_MIN})
        begin
            res_clamp = RES_MIN;
        end
        else if (value_reg > {22'd0, RES_MAX})
        begin
            res_clamp = RES_MAX;
        end
        else
        begin
            res_clamp = value_reg[4:0];
        end
        duty_sat  = (value_reg > {10'd0, DUTY_MAX}) ? DUTY_MAX : value_reg[16:0];
        eff_freq  = ovr_f_reg[rd_idx] ? freq_rd : glob_freq_reg;
        eff_res   = ovr_r_reg[rd_idx] ? res_rd : glob_res_reg;
        hit       = bound_reg[idx_reg] && (pin_rd == pin_reg);
        free_here = !bound_reg[idx_reg];
        out_free  = !out_vld_reg || !out_stall;
        ch_wide   = {4'd0, ch_reg};
        idx_wide  = {4'd0, idx_reg};
    end

    // servo: angle or pulse width to duty, divide by reciprocal then correct once
    always_comb
    begin
        lt_deg = value_reg < SERVO_DEG_LIM;
        us_hi  = value_reg >= SERVO_US_MID;
        if (lt_deg)
        begin
            diff = value_reg[11:0];
        end
        else if (us_hi)
        begin
            diff = 12'(value_reg - SERVO_US_MID);
        end
        else
        begin
            diff = 12'(SERVO_US_MID - value_reg);
        end
        prod_calc = {9'd0, diff} * {12'd0, SERVO_GAIN};
        recip     = us_reg ? RECIP_US : RECIP_DEG;
        div_d     = us_reg ? DIV_US : DIV_DEG;
        q_prod    = {14'd0, prod_reg} * {21'd0, recip};
        rem       = {1'b0, prod_reg} - ({12'd0, q0_reg} * {11'd0, div_d});
        q_fix     = q0_reg + {9'd0, (rem >= {11'd0, div_d})};
        sv_duty   = neg_reg ? (SERVO_BASE - {7'd0, q_fix}) : (SERVO_BASE + {7'd0, q_fix});
    end

    always_comb
    begin
        new_res.action  = ACT_ATTACH;
        new_res.channel = ch_wide[3:0];
        new_res.pin     = pin_reg;
        new_res.freq    = eff_freq;
        new_res.res     = eff_res;
        new_res.duty    = '0;
        case (cmd.kind)
            K_ATTACH_CH:
            begin
            end
            K_ATTACH_IDX:
            begin
                new_res.channel = idx_wide[3:0];
                new_res.pin     = pin_rd;
            end
            K_DUTY:
            begin
                new_res.action = ACT_WRITE;
                new_res.freq   = '0;
                new_res.res    = '0;
                new_res.duty   = duty_sat;
            end
            K_SERVO_SETUP:
            begin
                new_res.action = ACT_SETUP;
                new_res.freq   = SERVO_FREQ;
                new_res.res    = SERVO_RES;
            end
            K_SERVO_DUTY:
            begin
                new_res.action = ACT_WRITE;
                new_res.freq   = '0;
                new_res.res    = '0;
                new_res.duty   = sv_duty;
            end
            K_SET_FREQ:
            begin
                new_res.freq = freq_sat;
            end
            K_SET_RES:
            begin
                new_res.res = res_clamp;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        idx_next        = idx_reg;
        ch_next         = ch_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        bound_next      = bound_reg;
        ovr_f_next      = ovr_f_reg;
        ovr_r_next      = ovr_r_reg;
        glob_freq_next  = glob_freq_reg;
        glob_res_next   = glob_res_reg;
        if (cmd.load)
        begin
            idx_next        = '0;
            free_found_next = 1'b0;
        end
        if (cmd.glob_wr)
        begin
            if (cmd_reg == CMD_ALL_FREQ)
            begin
                glob_freq_next = freq_sat;
                ovr_f_next     = '0;
            end
            else
            begin
                glob_res_next = res_clamp;
                ovr_r_next    = '0;
            end
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.rec_free && !free_found_reg && free_here)
        begin
            free_next       = idx_reg;
            free_found_next = 1'b1;
        end
        if (cmd.set_ch_hit)
        begin
            ch_next = idx_reg;
        end
        if (cmd.claim)
        begin
            ch_next              = free_sel;
            bound_next[free_sel] = 1'b1;
        end
        if (cmd.push && (cmd.kind == K_SET_FREQ))
        begin
            ovr_f_next[ch_reg] = 1'b1;
        end
        if (cmd.push && (cmd.kind == K_SET_RES))
        begin
            ovr_r_next[ch_reg] = 1'b1;
        end
    end

    // staging: the newest result waits in pend until its successor or the end
    always_comb
    begin
        out_vld_next  = out_vld_reg && out_stall;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        if (cmd.push)
        begin
            if (pend_vld_reg)
            begin
                out_next      = pend_reg;
                out_last_next = 1'b0;
                out_vld_next  = 1'b1;
            end
            pend_next     = new_res;
            pend_vld_next = 1'b1;
        end
        if (cmd.flush)
        begin
            out_next      = pend_reg;
            out_last_next = 1'b1;
            out_vld_next  = 1'b1;
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            ch_reg         <= '0;
            free_reg       <= '0;
            free_found_reg <= 1'b0;
            bound_reg      <= '0;
            ovr_f_reg      <= '0;
            ovr_r_reg      <= '0;
            glob_freq_reg  <= FREQ_RESET;
            glob_res_reg   <= RES_RESET;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            ch_reg         <= ch_next;
            free_reg       <= free_next;
            free_found_reg <= free_found_next;
            bound_reg      <= bound_next;
            ovr_f_reg      <= ovr_f_next;
            ovr_r_reg      <= ovr_r_next;
            glob_freq_reg  <= glob_freq_next;
            glob_res_reg   <= glob_res_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            pin_reg   <= pin;
            value_reg <= value;
        end
        if (cmd.sv_mul)
        begin
            prod_reg <= prod_calc;
            neg_reg  <= !lt_deg && !us_hi;
            us_reg   <= !lt_deg;
        end
        if (cmd.sv_div)
        begin
            q0_reg <= q_prod[RECIP_SHIFT+9:RECIP_SHIFT];
        end
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        st.command    = cmd_reg;
        st.hit        = hit;
        st.free_here  = free_here;
        st.free_found = free_found_reg;
        st.idx_last   = idx_reg == LAST_IDX;
        st.out_free   = out_free;
        st.pend_vld   = pend_vld_reg;
        st.servo_wr   = value_reg < SERVO_US_LIM;
    end

    assign out_valid  = out_vld_reg;
    assign action     = out_reg.action;
    assign channel    = out_reg.channel;
    assign pin_out    = out_reg.pin;
    assign frequency  = out_reg.freq;
    assign resolution = out_reg.res;
    assign duty       = out_reg.duty;
    assign last       = out_last_reg;

    `PCA_ASSERT_NOW(a_no_overwrite, (cmd.push && pend_vld_reg) || cmd.flush, out_free)
    `PCA_ASSERT_NOW(a_claim_free, cmd.claim, !bound_reg[free_sel])
    `PCA_ASSERT_NEXT(a_flush_empties, cmd.flush, !pend_vld_reg && out_vld_reg && out_last_reg)

endmodule

// ===== rtl/pca_ctrl.sv =====
// Controller: sequences lookup, claim, command action, global sweep and flush
`include "pwm_channel_allocator_core_defines.svh"

module pca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pca_pkg::ctrl_stat_t st,
    output pca_pkg::ctrl_cmd_t  cmd
);

    import pca_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if ((st.command == CMD_ALL_FREQ) || (st.command == CMD_ALL_RES))
                begin
                    cmd.glob_wr = 1'b1;
                    state_next  = S_G_RD;
                end
                else if (st.command <= CMD_PIN_RES)
                begin
                    state_next = S_L_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_L_RD:
            begin
                state_next = S_L_CMP;
            end
            S_L_CMP:
            begin
                if (st.hit)
                begin
                    cmd.set_ch_hit = 1'b1;
                    state_next     = S_CH_RD;
                end
                else
                begin
                    cmd.rec_free = 1'b1;
                    if (st.idx_last)
                    begin
                        if (st.free_found || st.free_here)
                        begin
                            cmd.claim  = 1'b1;
                            state_next = S_CLAIM_RD;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_L_RD;
                    end
                end
            end
            S_CLAIM_RD:
            begin
                cmd.sel_ch = 1'b1;
                state_next = S_CLAIM_EMIT;
            end
            S_CLAIM_EMIT:
            begin
                cmd.sel_ch = 1'b1;
                cmd.kind   = K_ATTACH_CH;
                if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_ACT;
                end
            end
            S_CH_RD:
            begin
                cmd.sel_ch = 1'b1;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                cmd.sel_ch = 1'b1;
                case (st.command)
                    CMD_DUTY:     cmd.kind = K_DUTY;
                    CMD_SERVO:    cmd.kind = K_SERVO_SETUP;
                    CMD_PIN_FREQ: cmd.kind = K_SET_FREQ;
                    default:      cmd.kind = K_SET_RES;
                endcase
                if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = (st.command == CMD_SERVO) ? S_SV_MUL : S_FIN;
                end
            end
            S_SV_MUL:
            begin
                cmd.sv_mul = 1'b1;
                state_next = S_SV_DIV;
            end
            S_SV_DIV:
            begin
                cmd.sv_div = 1'b1;
                state_next = S_SV_OUT;
            end
            S_SV_OUT:
            begin
                cmd.kind = K_SERVO_DUTY;
                if (!st.servo_wr)
                begin
                    state_next = S_FIN;
                end
                else if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_G_RD:
            begin
                state_next = S_G_CMP;
            end
            S_G_CMP:
            begin
                cmd.kind = K_ATTACH_IDX;
                if (st.free_here || st.out_free)
                begin
                    cmd.push = !st.free_here;
                    if (st.idx_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_G_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (!st.pend_vld)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PCA_ASSERT_NOW(a_idle_drained, state_reg == S_IDLE, !st.pend_vld)
    `PCA_ASSERT_NEXT(a_load_dispatch, cmd.load, state_reg == S_DISP)
    `PCA_ASSERT_NOW(a_push_flush_excl, cmd.push, !cmd.flush && !cmd.load)

endmodule
